// ===== rtl/core/gso_pkg.sv =====
package gso_pkg;

    // item field widths
    localparam int COORD_W  = 14;
    localparam int STATUS_W = 2;

    // largest coordinate that fits the fixed point field
    localparam logic [31:0] COORD_MAX = 32'h0000_3FFF;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_KEEP  = 2'd0,
        ST_SNAP  = 2'd1,
        ST_NONE  = 2'd2,
        ST_CLEAR = 2'd3
    } status_t;

    // occupancy map port strobes
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } map_ctl_t;

endpackage

// ===== rtl/core/gso_occ_map.sv =====
module gso_occ_map #(
    parameter int ROW_BITS  = 6,
    parameter int ROW_WIDTH = 64
) (
    input  logic                  clk,
    input  gso_pkg::map_ctl_t     ctl,
    input  logic [ROW_BITS-1:0]   rd_addr,
    input  logic [ROW_BITS-1:0]   wr_addr,
    input  logic [ROW_WIDTH-1:0]  wr_data,
    output logic [ROW_WIDTH-1:0]  rd_data
);
    import gso_pkg::*;

    localparam int DEPTH = 1 << ROW_BITS;

    logic [ROW_WIDTH-1:0] map_mem [DEPTH];
    logic [ROW_WIDTH-1:0] rd_row_reg;

    // one grid row per word, registered read
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_row_reg <= map_mem[rd_addr];
        end
    end

    assign rd_data = rd_row_reg;

endmodule

// ===== rtl/core/grid_snap_with_occupancy_core.sv =====
// place item: corners are tried in turn, each in the grid read in S_RD and checked in S_CHK
//   and each off it skipped in S_RD; a free corner is marked in the check, then S_FIN follows
// clear item: one row zeroed per cycle by the sweep in S_CLR, then S_FIN follows
// one item at a time; in_ready returns as the result enters the output register
// reset: asynchronous, active low; after reset the map is cleared by the same row sweep,
//   during which no item is accepted
module grid_snap_with_occupancy_core #(
    parameter int GRID_X_BITS = 6,
    parameter int GRID_Y_BITS = 6,
    parameter int FRAC_BITS   = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         command,
    input  logic [gso_pkg::COORD_W-1:0]  x_coord,
    input  logic [gso_pkg::COORD_W-1:0]  y_coord,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [gso_pkg::COORD_W-1:0]  new_x,
    output logic [gso_pkg::COORD_W-1:0]  new_y,
    output logic [gso_pkg::STATUS_W-1:0] status
);
    import gso_pkg::*;

    localparam int          GRID_W  = 1 << GRID_X_BITS;
    localparam int          GC_W    = COORD_W + 1;
    localparam logic [31:0] FMASK   = (32'd1 << FRAC_BITS) - 32'd1;
    localparam logic [31:0] GRID_WL = 32'd1 << GRID_X_BITS;
    localparam logic [31:0] GRID_HL = 32'd1 << GRID_Y_BITS;

    typedef enum logic [4:0] {
        S_CLR  = 5'b00001,
        S_IDLE = 5'b00010,
        S_RD   = 5'b00100,
        S_CHK  = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    state_t                   state_reg, state_next;
    logic [COORD_W-1:0]       x_reg, x_next;
    logic [COORD_W-1:0]       y_reg, y_next;
    logic [1:0]               k_reg, k_next;
    logic                     int_reg, int_next;
    logic                     emit_reg, emit_next;
    logic [GRID_Y_BITS-1:0]   cnt_reg, cnt_next;
    logic [COORD_W-1:0]       res_x_reg, res_x_next;
    logic [COORD_W-1:0]       res_y_reg, res_y_next;
    status_t                  res_st_reg, res_st_next;
    logic                     out_valid_reg, out_valid_next;
    logic [COORD_W-1:0]       out_x_reg, out_x_next;
    logic [COORD_W-1:0]       out_y_reg, out_y_next;
    status_t                  out_st_reg, out_st_next;

    logic [GC_W-1:0]          xd, xu, yd, yu, gx, gy;
    logic [31:0]              gx_fix, gy_fix;
    logic                     in_grid;
    logic                     accept;
    logic                     cell_bit;
    logic [GRID_X_BITS-1:0]   col;
    logic [GRID_Y_BITS-1:0]   row;
    map_ctl_t                 map_ctl;
    logic [GRID_Y_BITS-1:0]   map_wr_addr;
    logic [GRID_W-1:0]        map_wr_data;
    logic [GRID_W-1:0]        map_rd_data;

    // floor and ceiling grid coordinates of the held position
    always_comb
    begin
        xd = GC_W'({1'b0, x_reg} >> FRAC_BITS);
        yd = GC_W'({1'b0, y_reg} >> FRAC_BITS);
        xu = xd + GC_W'((32'(x_reg) & FMASK) != 32'd0);
        yu = yd + GC_W'((32'(y_reg) & FMASK) != 32'd0);
    end

    // current corner: bit 1 picks the x ceiling, bit 0 the y ceiling
    always_comb
    begin
        gx      = k_reg[1] ? xu : xd;
        gy      = k_reg[0] ? yu : yd;
        gx_fix  = 32'(gx) << FRAC_BITS;
        gy_fix  = 32'(gy) << FRAC_BITS;
        in_grid = (32'(gx) < GRID_WL) && (32'(gy) < GRID_HL)
                  && (gx_fix <= COORD_MAX) && (gy_fix <= COORD_MAX);
        col     = gx[GRID_X_BITS-1:0];
        row     = gy[GRID_Y_BITS-1:0];
    end

    assign cell_bit = map_rd_data[col];
    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    // map row store
    gso_occ_map #(
        .ROW_BITS  (GRID_Y_BITS),
        .ROW_WIDTH (GRID_W)
    ) u_map (
        .clk     (clk),
        .ctl     (map_ctl),
        .rd_addr (row),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data),
        .rd_data (map_rd_data)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        k_next         = k_reg;
        int_next       = int_reg;
        emit_next      = emit_reg;
        cnt_next       = cnt_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        res_st_next    = res_st_reg;
        map_ctl        = '0;
        map_wr_addr    = row;
        map_wr_data    = map_rd_data | (GRID_W'(1) << col);

        unique case (state_reg)
            S_CLR:
            begin
                map_ctl.wr_en = 1'b1;
                map_wr_addr   = cnt_reg;
                map_wr_data   = '0;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    res_x_next  = '0;
                    res_y_next  = '0;
                    res_st_next = ST_CLEAR;
                    state_next  = emit_reg ? S_FIN : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (command)
                    begin
                        emit_next  = 1'b1;
                        cnt_next   = '0;
                        state_next = S_CLR;
                    end
                    else
                    begin
                        x_next     = x_coord;
                        y_next     = y_coord;
                        k_next     = '0;
                        int_next   = ((32'(x_coord) & FMASK) == 32'd0)
                                     && ((32'(y_coord) & FMASK) == 32'd0);
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                res_x_next = x_reg;
                res_y_next = y_reg;
                if (in_grid)
                begin
                    map_ctl.rd_en = 1'b1;
                    state_next    = S_CHK;
                end
                else if (int_reg)
                begin
                    res_st_next = ST_KEEP;
                    state_next  = S_FIN;
                end
                else if (k_reg == 2'd3)
                begin
                    res_st_next = ST_NONE;
                    state_next  = S_FIN;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end
            S_CHK:
            begin
                if (!cell_bit)
                begin
                    // free corner: mark it and move there
                    map_ctl.wr_en = 1'b1;
                    if (int_reg)
                    begin
                        res_st_next = ST_KEEP;
                    end
                    else
                    begin
                        res_x_next  = gx_fix[COORD_W-1:0];
                        res_y_next  = gy_fix[COORD_W-1:0];
                        res_st_next = ST_SNAP;
                    end
                    state_next = S_FIN;
                end
                else if (int_reg)
                begin
                    res_st_next = ST_KEEP;
                    state_next  = S_FIN;
                end
                else if (k_reg == 2'd3)
                begin
                    res_st_next = ST_NONE;
                    state_next  = S_FIN;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_RD;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    emit_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_st_next    = out_st_reg;
        if (state_reg == S_FIN && (!out_valid_reg || out_ready))
        begin
            out_valid_next = 1'b1;
            out_x_next     = res_x_reg;
            out_y_next     = res_y_reg;
            out_st_next    = res_st_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            cnt_reg       <= '0;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            int_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            int_reg       <= int_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        res_x_reg  <= res_x_next;
        res_y_reg  <= res_y_next;
        res_st_reg <= res_st_next;
        out_x_reg  <= out_x_next;
        out_y_reg  <= out_y_next;
        out_st_reg <= out_st_next;
    end

    assign out_valid = out_valid_reg;
    assign new_x     = out_x_reg;
    assign new_y     = out_y_reg;
    assign status    = out_st_reg;

    // a result only appears after the sequencer finished an item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside finish state");

    // a clear item starts the row sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command) |=> (state_reg == S_CLR && cnt_reg == '0))
        else $error("clear item did not start sweep");

    // cleared results carry a zero position
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_st_reg == ST_CLEAR) |-> (out_x_reg == '0 && out_y_reg == '0))
        else $error("cleared result with nonzero position");

    // snapped positions sit on grid points
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_st_reg == ST_SNAP)
        |-> ((32'(out_x_reg) & FMASK) == 32'd0 && (32'(out_y_reg) & FMASK) == 32'd0))
        else $error("snapped result off grid");

    // the map is written only by the sweep or a corner check
    assert property (@(posedge clk) disable iff (!rst_n)
        map_ctl.wr_en |-> (state_reg == S_CLR || (state_reg == S_CHK && !cell_bit)))
        else $error("unexpected map write");

endmodule
